@@ src/stok_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    // Output stream payload: kind, value, start_offset, length, line_number, padded to bytes.
    localparam int TOKEN_BITS = 3 + 32 + 16 + 16 + 16;
    localparam int TDATA_BITS = ((TOKEN_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        K_END   = 3'd0,
        K_IDENT = 3'd1,
        K_INT   = 3'd2,
        K_SYM   = 3'd3,
        K_STR   = 3'd4,
        K_CHAR  = 3'd5,
        K_ERR   = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_IDENT  = 4'd1,
        M_DEC    = 4'd2,
        M_BSL    = 4'd3,
        M_HEX    = 4'd4,
        M_STR    = 4'd5,
        M_STRESC = 4'd6,
        M_CH0    = 4'd7,
        M_CHESC  = 4'd8,
        M_CHSKIP = 4'd9,
        M_SYM    = 4'd10,
        M_CMT    = 4'd11,
        M_ERR    = 4'd12
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [15:0] start_offset;
        logic [15:0] length;
        logic [15:0] line_number;
        logic        last;
    } t_token;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_X      = 8'd120;

    function automatic logic is_alpha_byte(input logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
    endfunction

    function automatic logic is_dec_byte(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec_byte(c) || (c >= 8'd65 && c <= 8'd70);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha_byte(c) || is_dec_byte(c) || c == 8'd95;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    // Two-character symbols: .. ++ && || == // >= <= != ->
    function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
        logic same;
        same = (a == b) && (a == 8'd46 || a == 8'd43 || a == 8'd38 ||
                            a == 8'd124 || a == 8'd61 || a == 8'd47);
        return same || (b == 8'd61 && (a == 8'd62 || a == 8'd60 || a == 8'd33)) ||
               (a == 8'd45 && b == 8'd62);
    endfunction

    function automatic logic [7:0] char_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'd48:   r = 8'd0;
            8'd110:  r = 8'd10;
            8'd116:  r = 8'd9;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_token make_token(input t_kind kind, input logic [31:0] value,
                                          input logic [15:0] offset, input logic [15:0] len,
                                          input logic [15:0] line);
        t_token t;
        t.kind         = kind;
        t.value        = value;
        t.start_offset = offset;
        t.length       = len;
        t.line_number  = line;
        t.last         = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

@@ src/stok_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stok_scan #(
    parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_byte,
    output stok_pkg::t_token     o_res0,
    output stok_pkg::t_token     o_res1,
    output logic [1:0]           o_nres
);
    import stok_pkg::*;

    t_mode                   r_mode, n_mode;
    logic [31:0]             r_acc, n_acc;
    logic [OFFSET_BITS-1:0]  r_pos, n_pos;
    logic [15:0]             r_line, n_line;
    logic [OFFSET_BITS-1:0]  r_tstart, n_tstart;
    logic [15:0]             r_tline, n_tline;
    logic [15:0]             r_blen, n_blen;
    logic [7:0]              r_pend, n_pend;

    t_token      res [2];
    logic [1:0]  nres;
    logic        restart;
    logic [31:0] pos_ext;
    logic [31:0] tstart_ext;
    logic [15:0] pos16;
    logic [15:0] tstart16;
    logic [3:0]  hex_val;
    logic [7:0]  b;

    assign b          = i_byte;
    assign pos_ext    = 32'(r_pos);
    assign tstart_ext = 32'(r_tstart);
    assign pos16      = pos_ext[15:0];
    assign tstart16   = tstart_ext[15:0];
    assign hex_val    = (b > 8'd57) ? 4'(b - 8'd55) : 4'(b - CH_ZERO);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_line   = r_line;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_blen   = r_blen;
        n_pend   = r_pend;
        res[0]   = '0;
        res[1]   = '0;
        nres     = 2'd0;
        restart  = 1'b0;

        case (r_mode)
            M_IDENT: begin
                if (is_word(b)) begin
                    n_blen = sat_inc16(r_blen);
                end else begin
                    res[nres[0]] = make_token(K_IDENT, 32'd0, tstart16, r_blen, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end
            end
            M_DEC: begin
                if (is_dec_byte(b)) begin
                    n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} +
                            32'(b - CH_ZERO);
                end else begin
                    res[nres[0]] = make_token(K_INT, r_acc, tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end
            end
            M_BSL: begin
                if (b == CH_X) begin
                    n_mode = M_HEX;
                    n_acc  = 32'd0;
                end else begin
                    res[nres[0]] = make_token(K_SYM, 32'(CH_BSLASH), tstart16, 16'd0,
                                              r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end
            end
            M_HEX: begin
                if (is_hex(b)) begin
                    n_acc = {r_acc[27:0], hex_val};
                end else begin
                    res[nres[0]] = make_token(K_INT, r_acc, tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end
            end
            M_STR, M_STRESC: begin
                if (b == CH_NUL) begin
                    res[nres[0]] = make_token(K_STR, 32'd0, tstart16, r_blen, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end else if (r_mode == M_STR && b == CH_DQUOTE) begin
                    res[nres[0]] = make_token(K_STR, 32'd0, tstart16, r_blen, r_tline);
                    nres = nres + 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    n_blen = sat_inc16(r_blen);
                    n_mode = (r_mode == M_STR && b == CH_BSLASH) ? M_STRESC : M_STR;
                end
            end
            M_CH0: begin
                if (b == CH_NUL) begin
                    restart = 1'b1;
                end else if (b == CH_SQUOTE) begin
                    res[nres[0]] = make_token(K_CHAR, 32'd0, tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    n_mode = M_IDLE;
                end else if (b == CH_BSLASH) begin
                    n_mode = M_CHESC;
                end else begin
                    n_pend = b;
                    n_mode = M_CHSKIP;
                end
            end
            M_CHESC: begin
                if (b == CH_NUL) begin
                    res[nres[0]] = make_token(K_CHAR, 32'd0, tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end else begin
                    n_pend = char_escape(b);
                    n_mode = M_CHSKIP;
                end
            end
            M_CHSKIP: begin
                if (b == CH_NUL) begin
                    res[nres[0]] = make_token(K_CHAR, 32'(r_pend), tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end else if (b == CH_SQUOTE) begin
                    res[nres[0]] = make_token(K_CHAR, 32'(r_pend), tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_SYM: begin
                if (is_pair(r_pend, b)) begin
                    if (b == CH_SLASH) begin
                        n_mode = M_CMT;
                    end else begin
                        res[nres[0]] = make_token(K_SYM, {16'd0, b, r_pend}, tstart16,
                                                  16'd0, r_tline);
                        nres = nres + 2'd1;
                        n_mode = M_IDLE;
                    end
                end else begin
                    res[nres[0]] = make_token(K_SYM, 32'(r_pend), tstart16, 16'd0, r_tline);
                    nres = nres + 2'd1;
                    restart = 1'b1;
                end
            end
            M_CMT: begin
                if (b == CH_NUL || b == CH_LF) begin
                    restart = 1'b1;
                end
            end
            M_ERR: begin
                // Everything up to the end of text is dropped.
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        // The byte that ended a token (or any byte between tokens) opens the next one.
        if (restart) begin
            n_mode = M_IDLE;
            if (b == CH_NUL) begin
                res[nres[0]] = make_token(K_END, 32'd0, pos16, 16'd0, r_line);
                nres = nres + 2'd1;
            end else if (b > CH_SPACE) begin
                n_tstart = r_pos;
                n_tline  = r_line;
                if (is_alpha_byte(b)) begin
                    n_mode = M_IDENT;
                    n_blen = 16'd1;
                end else if (is_dec_byte(b)) begin
                    n_mode = M_DEC;
                    n_acc  = 32'(b - CH_ZERO);
                end else if (b == CH_BSLASH) begin
                    n_mode = M_BSL;
                end else if (b == CH_DQUOTE) begin
                    n_mode   = M_STR;
                    n_tstart = r_pos + OFFSET_BITS'(1);
                    n_blen   = 16'd0;
                end else if (b == CH_SQUOTE) begin
                    n_mode = M_CH0;
                end else if (is_punct(b)) begin
                    n_mode = M_SYM;
                    n_pend = b;
                end else begin
                    res[nres[0]] = make_token(K_ERR, 32'(b), pos16, 16'd0, r_line);
                    nres = nres + 2'd1;
                    n_mode = M_ERR;
                end
            end
        end

        if (b == CH_NUL) begin
            n_mode   = M_IDLE;
            n_acc    = 32'd0;
            n_pos    = '0;
            n_line   = 16'd1;
            n_tstart = '0;
            n_tline  = 16'd1;
            n_blen   = 16'd0;
            n_pend   = 8'd0;
        end else begin
            n_pos = r_pos + OFFSET_BITS'(1);
            if (b == CH_LF) begin
                n_line = sat_inc16(r_line);
            end
        end

        res[0].last = (nres == 2'd1);
        res[1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_acc    <= 32'd0;
            r_pos    <= '0;
            r_line   <= 16'd1;
            r_tstart <= '0;
            r_tline  <= 16'd1;
            r_blen   <= 16'd0;
            r_pend   <= 8'd0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_blen   <= n_blen;
            r_pend   <= n_pend;
        end
    end

    assign o_res0 = res[0];
    assign o_res1 = res[1];
    assign o_nres = nres;

endmodule

`default_nettype wire

@@ src/stok_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stok_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_cnt,
    input  wire stok_pkg::t_token  i_d0,
    input  wire stok_pkg::t_token  i_d1,
    output logic [1:0]             o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output stok_pkg::t_token       o_head
);
    import stok_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_token     r_q0, n_q0;
    t_token     r_q1, n_q1;
    logic       pop;
    logic [1:0] kept;
    t_token     e0;

    assign pop  = (r_cnt != 2'd0) && i_ready;
    assign kept = r_cnt - {1'b0, pop};
    assign e0   = pop ? r_q1 : r_q0;

    // Entries that survive the pop shift to the head; new requests fill behind them.
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = kept + i_push_cnt;
        case (kept)
            2'd0: begin
                n_q0 = i_d0;
                n_q1 = i_d1;
            end
            2'd1: begin
                n_q0 = e0;
                n_q1 = i_d0;
            end
            default: begin
                n_q0 = r_q0;
                n_q1 = r_q1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_free  = 2'd2 - r_cnt;
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;

endmodule

`default_nettype wire

@@ src/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] text_byte
// m_axis    out        tdata: kind, value, start_offset, length, line_number; tlast = last
//
// A text byte is registered on acceptance and scanned while it is held in the input register;
// its results go into the output queue, whose head entry is presented on m_axis.
// One byte per cycle is sustained while m_axis is ready and each byte yields at most one
// result; a byte that yields two results waits until the output queue is empty, and the
// next byte with a result waits while the queue is full, even if an entry is leaving.
// Reset is synchronous and active low; it empties the input register and output queue.
// Output stalls back up through the queue into the input register and then s_axis tready.

module source_text_tokenizer #(
    parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [7:0]                      i_s_axis_tdata,  // [7:0] text_byte
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [2:0] kind, [34:3] value, [50:35] start_offset, [66:51] length,
    // [82:67] line_number, upper bits zero
    output logic [stok_pkg::TDATA_BITS-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import stok_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       process;
    logic       in_fire;
    t_token     res0, res1, head;
    logic [1:0] nres;
    logic [1:0] free;
    logic [1:0] push_cnt;

    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign process         = r_in_valid && (nres <= free);
    assign o_s_axis_tready = !r_in_valid || process;
    assign push_cnt        = process ? nres : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    stok_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (process),
        .i_byte  (r_in_byte),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_nres  (nres)
    );

    stok_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_d0       (res0),
        .i_d1       (res1),
        .o_free     (free),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_head     (head)
    );

    assign o_m_axis_tdata = TDATA_BITS'({head.line_number, head.length, head.start_offset,
                                         head.value, head.kind});
    assign o_m_axis_tlast = head.last;

endmodule

`default_nettype wire

@@ src/stok_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stok_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [stok_pkg::TDATA_BITS-1:0] o_m_axis_tdata,
    input wire logic                        o_m_axis_tlast
);
    import stok_pkg::*;

    // The queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // End of text and error end are always the final result of their byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2:0] == K_END || o_m_axis_tdata[2:0] == K_ERR)
            |-> o_m_axis_tlast)
        else $error("end or error result without tlast");

    // Only identifiers and strings carry a length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] != K_IDENT && o_m_axis_tdata[2:0] != K_STR
            |-> o_m_axis_tdata[66:51] == 16'd0)
        else $error("nonzero length on a token without a body");

    // Line numbers start at one and saturate, so they are never zero.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[82:67] != 16'd0)
        else $error("line number zero");

endmodule

bind source_text_tokenizer stok_checker u_stok_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

@@ tb/source_text_tokenizer_test.sv @@
`timescale 1ns / 1ps

module source_text_tokenizer_test;
    import stok_pkg::*;

    localparam int RANDOM_BYTES  = 380;
    localparam int DRAIN_EVERY   = 150;
    localparam int QUIET_TAIL    = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam string SIGNS      = "!#$%&()*+,-./:;<=>?@[]^_`{|}~";
    localparam string HEX_DIGITS = "0123456789ABCDEF";

    typedef struct packed {
        logic       drain;
        logic [7:0] text;
    } text_req_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic [7:0]                  s_data = 8'd0;
    logic                        m_ready = 1'b0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic [TDATA_BITS-1:0]       o_m_axis_tdata;
    logic                        o_m_axis_tlast;

    source_text_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),           // [7:0] text_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // [2:0] kind, [34:3] value, [50:35] start_offset, [66:51] length,
        // [82:67] line_number, upper bits zero
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    text_req_t pending[$];
    t_token    expected_tokens[$];
    t_token    step_tokens[$];

    int fails = 0;
    int tokens_checked = 0;
    int bytes_done = 0;
    int texts_done = 0;
    int quiet_cycles = 0;
    int kind_seen[0:7];

    // Scanner shadow state.
    t_mode       scan_state = M_IDLE;
    logic [31:0] num_acc = 32'd0;
    logic [15:0] next_offset = 16'd0;
    logic [15:0] line_now = 16'd1;
    logic [15:0] tok_offset = 16'd0;
    logic [15:0] tok_line = 16'd1;
    logic [15:0] tok_length = 16'd0;
    logic [7:0]  held_char = 8'd0;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hexdig(input logic [7:0] c);
        return is_num(c) || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_alpha(c) || is_num(c) || c == "_";
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic pairs_with(input logic [7:0] a, input logic [7:0] b);
        if (a == b && (a == "." || a == "+" || a == "&" || a == "|" || a == "=" || a == "/"))
            return 1'b1;
        if (b == "=" && (a == ">" || a == "<" || a == "!"))
            return 1'b1;
        return a == "-" && b == ">";
    endfunction

    function automatic logic [7:0] esc_value(input logic [7:0] c);
        if (c == "0") return 8'd0;
        if (c == "n") return 8'd10;
        if (c == "t") return 8'd9;
        return c;
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic emit_token(input t_kind k, input logic [31:0] v, input logic [15:0] off,
                              input logic [15:0] len, input logic [15:0] ln);
        t_token t;
        t.kind         = k;
        t.value        = v;
        t.start_offset = off;
        t.length       = len;
        t.line_number  = ln;
        t.last         = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic clear_scan();
        scan_state  = M_IDLE;
        num_acc     = 32'd0;
        next_offset = 16'd0;
        line_now    = 16'd1;
        tok_offset  = 16'd0;
        tok_line    = 16'd1;
        tok_length  = 16'd0;
        held_char   = 8'd0;
    endtask

    // Scans a byte seen between tokens; a 0 gives the end token.
    task automatic begin_token(input logic [7:0] b, input logic [15:0] at);
        scan_state = M_IDLE;
        if (b == 8'd0) begin
            emit_token(K_END, 32'd0, at, 16'd0, line_now);
        end else if (b > 8'd32) begin
            tok_offset = at;
            tok_line   = line_now;
            if (is_alpha(b)) begin
                scan_state = M_IDENT;
                tok_length = 16'd1;
            end else if (is_num(b)) begin
                scan_state = M_DEC;
                num_acc    = {24'd0, b} - 32'd48;
            end else if (b == "\\") begin
                scan_state = M_BSL;
            end else if (b == "\"") begin
                scan_state = M_STR;
                tok_offset = at + 16'd1;
                tok_length = 16'd0;
            end else if (b == "'") begin
                scan_state = M_CH0;
            end else if (is_sign(b)) begin
                scan_state = M_SYM;
                held_char  = b;
            end else begin
                emit_token(K_ERR, {24'd0, b}, at, 16'd0, line_now);
                scan_state = M_ERR;
            end
        end
    endtask

    // Advances the shadow scanner by one byte and queues the tokens it ends.
    task automatic scan_text_byte(input logic [7:0] b);
        logic [15:0] at;
        t_token      final_tok;
        at = next_offset;
        case (scan_state)
            M_IDENT: begin
                if (is_name_char(b)) begin
                    tok_length = bump16(tok_length);
                end else begin
                    emit_token(K_IDENT, 32'd0, tok_offset, tok_length, tok_line);
                    begin_token(b, at);
                end
            end
            M_DEC: begin
                if (is_num(b)) begin
                    num_acc = num_acc * 32'd10 + ({24'd0, b} - 32'd48);
                end else begin
                    emit_token(K_INT, num_acc, tok_offset, 16'd0, tok_line);
                    begin_token(b, at);
                end
            end
            M_BSL: begin
                if (b == "x") begin
                    scan_state = M_HEX;
                    num_acc    = 32'd0;
                end else begin
                    emit_token(K_SYM, 32'd92, tok_offset, 16'd0, tok_line);
                    begin_token(b, at);
                end
            end
            M_HEX: begin
                if (is_hexdig(b)) begin
                    num_acc = num_acc * 32'd16 +
                              ({24'd0, b} - ((b > "9") ? 32'd55 : 32'd48));
                end else begin
                    emit_token(K_INT, num_acc, tok_offset, 16'd0, tok_line);
                    begin_token(b, at);
                end
            end
            M_STR, M_STRESC: begin
                if (b == 8'd0) begin
                    emit_token(K_STR, 32'd0, tok_offset, tok_length, tok_line);
                    begin_token(b, at);
                end else if (scan_state == M_STR && b == "\"") begin
                    emit_token(K_STR, 32'd0, tok_offset, tok_length, tok_line);
                    scan_state = M_IDLE;
                end else begin
                    tok_length = bump16(tok_length);
                    scan_state = (scan_state == M_STR && b == "\\") ? M_STRESC : M_STR;
                end
            end
            M_CH0: begin
                if (b == 8'd0) begin
                    begin_token(b, at);
                end else if (b == "'") begin
                    emit_token(K_CHAR, 32'd0, tok_offset, 16'd0, tok_line);
                    scan_state = M_IDLE;
                end else if (b == "\\") begin
                    scan_state = M_CHESC;
                end else begin
                    held_char  = b;
                    scan_state = M_CHSKIP;
                end
            end
            M_CHESC: begin
                if (b == 8'd0) begin
                    emit_token(K_CHAR, 32'd0, tok_offset, 16'd0, tok_line);
                    begin_token(b, at);
                end else begin
                    held_char  = esc_value(b);
                    scan_state = M_CHSKIP;
                end
            end
            M_CHSKIP: begin
                if (b == 8'd0) begin
                    emit_token(K_CHAR, {24'd0, held_char}, tok_offset, 16'd0, tok_line);
                    begin_token(b, at);
                end else if (b == "'") begin
                    emit_token(K_CHAR, {24'd0, held_char}, tok_offset, 16'd0, tok_line);
                    scan_state = M_IDLE;
                end
            end
            M_SYM: begin
                if (pairs_with(held_char, b)) begin
                    if (b == "/") begin
                        scan_state = M_CMT;
                    end else begin
                        emit_token(K_SYM, {16'd0, b, held_char}, tok_offset, 16'd0, tok_line);
                        scan_state = M_IDLE;
                    end
                end else begin
                    emit_token(K_SYM, {24'd0, held_char}, tok_offset, 16'd0, tok_line);
                    begin_token(b, at);
                end
            end
            M_CMT: begin
                if (b == 8'd0 || b == 8'd10)
                    begin_token(b, at);
            end
            M_ERR: begin
            end
            default: begin
                begin_token(b, at);
            end
        endcase

        if (step_tokens.size() != 0) begin
            final_tok = step_tokens.pop_back();
            final_tok.last = 1'b1;
            step_tokens.push_back(final_tok);
        end
        while (step_tokens.size() != 0)
            expected_tokens.push_back(step_tokens.pop_front());

        if (b == 8'd0) begin
            clear_scan();
        end else begin
            next_offset = next_offset + 16'd1;
            if (b == 8'd10)
                line_now = bump16(line_now);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: token %0d field %s expected %0h got %0h",
                     $time, tokens_checked, name, want, got);
            fails++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        text_req_t r;
        r.drain = 1'b0;
        r.text  = b;
        pending.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    // The sender holds off until every queued token has come out.
    task automatic queue_drain();
        text_req_t r;
        r.drain = 1'b1;
        r.text  = 8'd0;
        pending.push_back(r);
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] pick_name_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52) return pick_letter();
        if (r < 62) return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] pick_printable();
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic add_random_token();
        int n;
        case ($urandom_range(0, 11))
            0, 1: begin
                queue_byte(pick_letter());
                repeat ($urandom_range(0, 6)) queue_byte(pick_name_char());
            end
            2: begin
                repeat ($urandom_range(1, 12)) queue_byte(8'("0" + $urandom_range(0, 9)));
            end
            3: begin
                queue_text("\\x");
                repeat ($urandom_range(0, 9))
                    queue_byte(HEX_DIGITS[$urandom_range(0, 15)]);
            end
            4, 5: begin
                queue_byte(SIGNS[$urandom_range(0, SIGNS.len() - 1)]);
                if ($urandom_range(0, 1) != 0)
                    queue_byte(SIGNS[$urandom_range(0, SIGNS.len() - 1)]);
            end
            6: begin
                queue_byte("\"");
                n = $urandom_range(0, 8);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            queue_byte("\\");
                            queue_byte(pick_printable());
                        end
                        1: queue_byte(8'd10);
                        default: queue_byte(pick_printable());
                    endcase
                end
                if ($urandom_range(0, 9) != 0)
                    queue_byte("\"");
            end
            7: begin
                queue_byte("'");
                case ($urandom_range(0, 3))
                    0: ;
                    1: begin
                        queue_byte("\\");
                        queue_byte(pick_printable());
                    end
                    default: queue_byte(pick_printable());
                endcase
                repeat ($urandom_range(0, 2)) queue_byte(pick_letter());
                queue_byte("'");
            end
            8: begin
                queue_text("//");
                repeat ($urandom_range(0, 6)) queue_byte(pick_printable());
                queue_byte(8'd10);
            end
            9: begin
                repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(1, 32)));
            end
            10: begin
                // Bytes above the printable range abort the text until the next 0.
                if ($urandom_range(0, 3) == 0) begin
                    queue_byte(8'($urandom_range(127, 255)));
                    queue_byte(8'd0);
                end else begin
                    queue_byte(8'($urandom_range(1, 126)));
                end
            end
            default: queue_byte(8'd0);
        endcase
        case ($urandom_range(0, 3))
            1: queue_byte(" ");
            2: queue_byte(8'd10);
            default: ;
        endcase
    endtask

    // Sender: offers queued text bytes, with bursts of idle cycles.
    int  send_span = 0;
    int  send_gap = 0;
    bit  send_gaps = 1'b0;

    always @(posedge i_clk) begin
        bit        load;
        text_req_t head;
        load = 1'b0;
        if (i_rst_n && (!s_valid || o_s_axis_tready)) begin
            if (send_span == 0) begin
                send_span = $urandom_range(16, 64);
                send_gaps = ($urandom_range(0, 2) != 0);
            end
            send_span--;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending.size() != 0) begin
                if (pending[0].drain) begin
                    if (!s_valid && expected_tokens.size() == 0)
                        head = pending.pop_front();
                end else if (send_gaps && pending.size() > QUIET_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 4);
                end else begin
                    head = pending.pop_front();
                    s_data <= head.text;
                    load = 1'b1;
                end
            end
            s_valid <= load;
        end
    end

    // Receiver: checks each token against the oldest expectation and
    // feeds accepted text bytes to the shadow scanner.
    int  recv_span = 0;
    int  recv_gap = 0;
    bit  recv_gaps = 1'b0;

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        logic   ready_next;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                got.kind         = t_kind'(o_m_axis_tdata[2:0]);
                got.value        = o_m_axis_tdata[34:3];
                got.start_offset = o_m_axis_tdata[50:35];
                got.length       = o_m_axis_tdata[66:51];
                got.line_number  = o_m_axis_tdata[82:67];
                got.last         = o_m_axis_tlast;
                kind_seen[got.kind]++;
                if (expected_tokens.size() == 0) begin
                    $display("%0t ns: token kind %0d value %0h expected none", $time,
                             got.kind, got.value);
                    fails++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("value", want.value, got.value);
                    check_field("start_offset", want.start_offset, got.start_offset);
                    check_field("length", want.length, got.length);
                    check_field("line_number", want.line_number, got.line_number);
                    check_field("last", want.last, got.last);
                    tokens_checked++;
                end
            end
            if (s_valid && o_s_axis_tready) begin
                scan_text_byte(s_data);
                bytes_done++;
                if (s_data == 8'd0)
                    texts_done++;
            end
            if ((o_m_axis_tvalid && m_ready) || (s_valid && o_s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (recv_span == 0) begin
                recv_span = $urandom_range(16, 64);
                recv_gaps = ($urandom_range(0, 2) != 0);
            end
            recv_span--;
            if (recv_gap > 0) begin
                recv_gap--;
                ready_next = 1'b0;
            end else if (recv_gaps && pending.size() > QUIET_TAIL &&
                         $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 4);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("%0t ns: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int start_size;
        foreach (kind_seen[k])
            kind_seen[k] = 0;

        // Identifier, decimal wrap, hex wrap, hex with no digits, lone backslash at the end.
        queue_text("a_Z9 4294967296 \\xFFFFFFFF1 \\xg \\");
        queue_byte(8'd0);
        // Every two-character symbol and a run of single ones.
        queue_text("..++&&||==>=<=!=->!-;~`@[^_{}");
        queue_byte(8'd0);
        // Line comment, newline counting, symbol ended by the text end.
        queue_text("p // note\n q/");
        queue_byte(8'd0);
        // Strings with escapes and newlines, then every character literal form.
        queue_text("\"s\\\"t\n\"'' 'a' '\\n' '\\t' '\\0' '\\q' 'bcd'");
        queue_byte(8'd0);
        queue_text("\"open");
        queue_byte(8'd0);
        queue_text("\"a\\");
        queue_byte(8'd0);
        queue_text("'");
        queue_byte(8'd0);
        queue_text("'c");
        queue_byte(8'd0);
        queue_text("'\\");
        queue_byte(8'd0);
        queue_byte(8'd1);
        queue_text("\t");
        queue_byte(8'd13);
        queue_text(" 7//x");
        queue_byte(8'd0);
        queue_byte(8'd0);
        // Unknown byte after an identifier, then ignored bytes up to the restart.
        queue_text("k");
        queue_byte(8'd127);
        queue_text("zz");
        queue_byte(8'd255);
        queue_byte(8'd0);
        queue_byte(8'd255);
        queue_byte(8'd0);
        queue_drain();

        start_size = pending.size();
        while (pending.size() - start_size < RANDOM_BYTES) begin
            add_random_token();
            if ((pending.size() - start_size) % DRAIN_EVERY < 4)
                queue_drain();
        end
        queue_byte(8'd0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || s_valid)
            @(posedge i_clk);
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Scanned %0d text bytes over %0d texts and checked %0d tokens.",
                 bytes_done, texts_done, tokens_checked);
        $display("Tokens by kind: end %0d, ident %0d, int %0d, symbol %0d, string %0d, %s",
                 kind_seen[K_END], kind_seen[K_IDENT], kind_seen[K_INT], kind_seen[K_SYM],
                 kind_seen[K_STR], $sformatf("char %0d, error %0d.", kind_seen[K_CHAR],
                 kind_seen[K_ERR]));
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ source_text_tokenizer.f @@
src/stok_pkg.sv
src/stok_scan.sv
src/stok_outq.sv
src/source_text_tokenizer.sv
src/stok_checker.sv
tb/source_text_tokenizer_test.sv
